// File: hw/rtl/pnsm_pkg.sv
// Shared types, constants and coefficient tables of the pink noise shaper and mixer.
package pnsm_pkg;

    // Fixed-point formats of the coefficients and of the gain register.
    localparam int COEF_BITS     = 17;
    localparam int COEF_SHIFT    = 16;
    localparam int GAIN_BITS     = 24;
    localparam int GAIN_SHIFT    = 24;
    localparam int TAP_ADDR_BITS = 3;
    localparam int NUM_TAPS      = 7;
    localparam int CFG_IDX_BITS  = 1;

    typedef logic signed [COEF_BITS-1:0] coef_t;
    typedef logic [TAP_ADDR_BITS-1:0]    tap_addr_t;
    typedef logic [GAIN_BITS-1:0]        gain_t;

    // Tap memory layout: six filter poles, then the delayed tap.
    localparam tap_addr_t FIRST_POLE = 3'd0;
    localparam tap_addr_t LAST_POLE  = 3'd5;
    localparam tap_addr_t DELAY_TAP  = 3'd6;

    // Coefficients of the direct tap, the delayed tap and the output normalization.
    localparam coef_t DIRECT_COEF = 17'sd35140;
    localparam coef_t DELAY_COEF  = 17'sd7597;
    localparam coef_t NORM_COEF   = 17'sd7209;

    localparam gain_t GAIN_RESET = 24'd16777;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_NOISE_COLOR = 1'b0,
        CFG_NOISE_GAIN  = 1'b1
    } cfg_idx_t;

    typedef enum logic {
        COLOR_WHITE = 1'b0,
        COLOR_PINK  = 1'b1
    } color_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FEED,
        ST_POLE,
        ST_UPD,
        ST_DIRECT,
        ST_DELAY,
        ST_DLYW,
        ST_NORM,
        ST_GAIN,
        ST_MIX
    } state_t;

    // Pole coefficient of each one-pole filter.
    function automatic coef_t pole_coef(input tap_addr_t idx);
        coef_t c;
        case (idx)
            3'd0:    c = 17'sd65461;
            3'd1:    c = 17'sd65098;
            3'd2:    c = 17'sd63504;
            3'd3:    c = 17'sd56787;
            3'd4:    c = 17'sd36045;
            3'd5:    c = -17'sd49912;
            default: c = '0;
        endcase
        return c;
    endfunction

    // Input weight of each one-pole filter.
    function automatic coef_t feed_coef(input tap_addr_t idx);
        coef_t c;
        case (idx)
            3'd0:    c = 17'sd3638;
            3'd1:    c = 17'sd4920;
            3'd2:    c = 17'sd10083;
            3'd3:    c = 17'sd20348;
            3'd4:    c = 17'sd34928;
            3'd5:    c = -17'sd1107;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// File: hw/rtl/pnsm_in_if.sv
// Input channel of the mixer: one clean sample and one white-noise sample per beat.
interface pnsm_in_if #(
    parameter int SAMPLE_BITS = 24
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] clean_sample;
    logic signed [SAMPLE_BITS-1:0] white_sample;

    modport source (output valid, output clean_sample, output white_sample, input ready);
    modport sink (input valid, input clean_sample, input white_sample, output ready);
endinterface

// File: hw/rtl/pnsm_out_if.sv
// Output channel of the mixer: one mixed sample per beat.
interface pnsm_out_if #(
    parameter int SAMPLE_BITS = 24
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] mixed_sample;

    modport source (output valid, output mixed_sample, input ready);
    modport sink (input valid, input mixed_sample, output ready);
endinterface

// File: hw/rtl/pink_noise_shaper_mixer.sv
// Pink or white noise shaper with gain, mixed into a clean audio stream.
//
// Each input beat carries a clean sample and a white-noise sample. In white mode the
// white sample is scaled by noise_gain; in pink mode it first drives six one-pole
// filters, a direct tap and a one-sample delayed tap, whose sum is scaled by 0.11.
// The noise is added to the clean sample and saturated. The seven filter states sit
// in a small synchronous memory and are updated by read, modify and write back; all
// products go through one shared registered multiplier. A pink sample passes a feed,
// pole and update step for each filter pole, then the direct tap, delayed tap,
// normalization, gain and mix steps before it reaches the output register; a white
// sample goes straight to the gain and mix steps. A new beat is taken only in the idle
// state, which follows the mix step. The next beat is taken as soon as the
// result sits in the output register; only a second finished result waits in the mix
// step until the sink takes the first. Filter states are zero after reset and change
// only in pink mode.
module pink_noise_shaper_mixer
    import pnsm_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int TAP_BITS    = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_idx,
    input  logic [GAIN_BITS-1:0]    cfg_data,
    pnsm_in_if.sink                 sample_in,
    pnsm_out_if.source              sample_out
);

    // Datapath widths.
    localparam int NW   = SAMPLE_BITS + 8;
    localparam int AW   = (TAP_BITS > NW) ? TAP_BITS : NW;
    localparam int BW   = GAIN_BITS + 1;
    localparam int PW   = AW + BW;
    localparam int SUMW = TAP_BITS + 4;
    localparam int ACCW = SAMPLE_BITS + 1;

    localparam logic signed [PW-1:0] COEF_HALF = PW'(1) << (COEF_SHIFT - 1);
    localparam logic signed [PW-1:0] GAIN_HALF = PW'(1) << (GAIN_SHIFT - 1);
    localparam logic signed [PW-1:0] TAP_MAX   = PW'({1'b0, {(TAP_BITS - 1){1'b1}}});
    localparam logic signed [PW-1:0] TAP_MIN   = ~TAP_MAX;
    localparam logic signed [PW-1:0] NOISE_MAX = PW'({1'b0, {(NW - 1){1'b1}}});
    localparam logic signed [PW-1:0] NOISE_MIN = -NOISE_MAX;
    localparam logic signed [PW-1:0] SMP_MAX   = PW'({1'b0, {(SAMPLE_BITS - 1){1'b1}}});
    localparam logic signed [PW-1:0] SMP_MIN   = ~SMP_MAX;

    // Control state.
    state_t                  state_reg, state_next;
    tap_addr_t               idx_reg, idx_next;
    logic                    out_valid_reg, out_valid_next;
    color_t                  color_reg;
    gain_t                   gain_reg;
    logic [NUM_TAPS-1:0]     tap_valid_reg;
    logic                    rvalid_reg;

    // Payload state.
    logic signed [SAMPLE_BITS-1:0] clean_reg, clean_next;
    logic signed [SAMPLE_BITS-1:0] white_reg, white_next;
    logic signed [ACCW-1:0]        acc_reg, acc_next;
    logic signed [SUMW-1:0]        sum_reg, sum_next;
    logic signed [NW-1:0]          noise_reg, noise_next;
    logic signed [PW-1:0]          prod_reg, prod_next;
    logic signed [SAMPLE_BITS-1:0] out_reg, out_next;

    // Tap memory.
    logic signed [TAP_BITS-1:0] tap_mem [NUM_TAPS];
    logic signed [TAP_BITS-1:0] rdata_reg;
    logic                       mem_re;
    logic                       mem_we;
    tap_addr_t                  raddr;
    tap_addr_t                  waddr;
    logic signed [TAP_BITS-1:0] wdata;

    // Shared multiplier operands and helpers.
    logic signed [AW-1:0]       mul_a;
    logic signed [BW-1:0]       mul_b;
    logic signed [TAP_BITS-1:0] tap_rd;
    logic signed [PW-1:0]       prod_rnd;
    logic signed [TAP_BITS-1:0] tap_new;
    logic signed [PW-1:0]       mix_sum;
    logic                       in_beat;
    logic                       out_free;

    function automatic logic signed [TAP_BITS-1:0] sat_tap(input logic signed [PW-1:0] x);
        logic signed [TAP_BITS-1:0] r;
        if (x > TAP_MAX)
            r = TAP_BITS'(TAP_MAX);
        else if (x < TAP_MIN)
            r = TAP_BITS'(TAP_MIN);
        else
            r = TAP_BITS'(x);
        return r;
    endfunction

    function automatic logic signed [NW-1:0] clamp_noise(input logic signed [PW-1:0] x);
        logic signed [NW-1:0] r;
        if (x > NOISE_MAX)
            r = NW'(NOISE_MAX);
        else if (x < NOISE_MIN)
            r = NW'(NOISE_MIN);
        else
            r = NW'(x);
        return r;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(input logic signed [PW-1:0] x);
        logic signed [SAMPLE_BITS-1:0] r;
        if (x > SMP_MAX)
            r = SAMPLE_BITS'(SMP_MAX);
        else if (x < SMP_MIN)
            r = SAMPLE_BITS'(SMP_MIN);
        else
            r = SAMPLE_BITS'(x);
        return r;
    endfunction

    // Handshake and shared values.
    assign sample_in.ready         = (state_reg == ST_IDLE);
    assign sample_out.valid        = out_valid_reg;
    assign sample_out.mixed_sample = out_reg;
    assign in_beat  = sample_in.valid && sample_in.ready;
    assign out_free = !out_valid_reg || sample_out.ready;
    assign tap_rd   = rvalid_reg ? rdata_reg : '0;
    assign prod_rnd = (prod_reg + COEF_HALF) >>> COEF_SHIFT;
    assign tap_new  = sat_tap(prod_rnd + PW'(acc_reg));
    assign mix_sum  = PW'(clean_reg) + ((prod_reg + GAIN_HALF) >>> GAIN_SHIFT);

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                    state_next = (color_reg == COLOR_PINK) ? ST_FEED : ST_GAIN;
            end
            ST_FEED:   state_next = ST_POLE;
            ST_POLE:   state_next = ST_UPD;
            ST_UPD:    state_next = (idx_reg == LAST_POLE) ? ST_DIRECT : ST_FEED;
            ST_DIRECT: state_next = ST_DELAY;
            ST_DELAY:  state_next = ST_DLYW;
            ST_DLYW:   state_next = ST_NORM;
            ST_NORM:   state_next = ST_GAIN;
            ST_GAIN:   state_next = ST_MIX;
            ST_MIX:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath control, memory access and multiplier operands per state.
    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !sample_out.ready;
        clean_next     = clean_reg;
        white_next     = white_reg;
        acc_next       = acc_reg;
        sum_next       = sum_reg;
        noise_next     = noise_reg;
        out_next       = out_reg;
        mul_a          = '0;
        mul_b          = '0;
        mem_re         = 1'b0;
        raddr          = FIRST_POLE;
        mem_we         = 1'b0;
        waddr          = FIRST_POLE;
        wdata          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    clean_next = SAMPLE_BITS'(sample_in.clean_sample);
                    white_next = SAMPLE_BITS'(sample_in.white_sample);
                    noise_next = NW'(sample_in.white_sample);
                    idx_next   = FIRST_POLE;
                    sum_next   = '0;
                    mem_re     = (color_reg == COLOR_PINK);
                    raddr      = FIRST_POLE;
                end
            end
            ST_FEED:
            begin
                mul_a = AW'(white_reg);
                mul_b = BW'(feed_coef(idx_reg));
            end
            ST_POLE:
            begin
                acc_next = ACCW'(prod_rnd);
                mul_a    = AW'(tap_rd);
                mul_b    = BW'(pole_coef(idx_reg));
            end
            ST_UPD:
            begin
                // Write the new pole state and fetch the next tap.
                mem_we   = 1'b1;
                waddr    = idx_reg;
                wdata    = tap_new;
                sum_next = sum_reg + SUMW'(tap_new);
                mem_re   = 1'b1;
                if (idx_reg == LAST_POLE)
                    raddr = DELAY_TAP;
                else
                begin
                    raddr    = idx_reg + 3'd1;
                    idx_next = idx_reg + 3'd1;
                end
            end
            ST_DIRECT:
            begin
                mul_a = AW'(white_reg);
                mul_b = BW'(DIRECT_COEF);
            end
            ST_DELAY:
            begin
                // Old delayed tap and the direct tap join the sum.
                sum_next = sum_reg + SUMW'(tap_rd) + SUMW'(prod_rnd);
                mul_a    = AW'(white_reg);
                mul_b    = BW'(DELAY_COEF);
            end
            ST_DLYW:
            begin
                mem_we = 1'b1;
                waddr  = DELAY_TAP;
                wdata  = sat_tap(prod_rnd);
                mul_a  = AW'(sat_tap(PW'(sum_reg)));
                mul_b  = BW'(NORM_COEF);
            end
            ST_NORM:
            begin
                noise_next = clamp_noise(prod_rnd);
            end
            ST_GAIN:
            begin
                mul_a = AW'(noise_reg);
                mul_b = BW'({1'b0, gain_reg});
            end
            ST_MIX:
            begin
                // The gain product stays in place while the output register is busy.
                mul_a = AW'(noise_reg);
                mul_b = BW'({1'b0, gain_reg});
                if (out_free)
                begin
                    out_next       = sat_smp(mix_sum);
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                idx_next = FIRST_POLE;
            end
        endcase
    end

    assign prod_next = PW'(mul_a) * PW'(mul_b);

    // Control registers and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= FIRST_POLE;
            out_valid_reg <= 1'b0;
            color_reg     <= COLOR_PINK;
            gain_reg      <= GAIN_RESET;
            tap_valid_reg <= '0;
            rvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (mem_we)
                tap_valid_reg[waddr] <= 1'b1;
            if (mem_re)
                rvalid_reg <= tap_valid_reg[raddr];
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_idx))
                    CFG_NOISE_COLOR: color_reg <= color_t'(cfg_data[0]);
                    CFG_NOISE_GAIN:  gain_reg  <= cfg_data;
                    default:         gain_reg  <= gain_reg;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        clean_reg <= clean_next;
        white_reg <= white_next;
        acc_reg   <= acc_next;
        sum_reg   <= sum_next;
        noise_reg <= noise_next;
        prod_reg  <= prod_next;
        out_reg   <= out_next;
    end

    // Tap memory with registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            tap_mem[waddr] <= wdata;
        if (mem_re)
            rdata_reg <= tap_mem[raddr];
    end

`ifndef ASSERT_OFF
    // A result is loaded only at the end of the mix step.
    a_out_from_mix: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_MIX)
        else $error("result loaded outside the mix step");

    // A white-mode beat goes straight to the gain step.
    a_white_path: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_in.valid && sample_in.ready && color_reg == COLOR_WHITE)
            |=> state_reg == ST_GAIN)
        else $error("white beat did not go to the gain step");

    // The tap memory is never read and written at one entry in the same cycle.
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> waddr != raddr)
        else $error("tap memory read and write collide");

    // The pole index stays within the pole bank while a sample is in work.
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> idx_reg <= LAST_POLE)
        else $error("pole index out of range");
`endif

endmodule

// File: tb/tb_pink_noise_shaper_mixer.sv
// Self-checking testbench of the pink noise shaper and mixer with its own fixed-point predictor.
module tb_pink_noise_shaper_mixer
    import pnsm_pkg::*;
();

    localparam int SAMPLE_W = 24;
    localparam int TAP_W    = 32;

    // Q.16 weights of the direct tap, the delayed tap and the 0.11 normalization.
    localparam longint DIRECT_W = 35140;
    localparam longint DELAY_W  = 7597;
    localparam longint NORM_W   = 7209;

    localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam gain_t GAIN_FULL = {GAIN_BITS{1'b1}};

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        sample_t clean;
        sample_t white;
    } sample_pair_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    cfg_idx_t                cfg_idx;
    logic [GAIN_BITS-1:0]    cfg_data;

    pnsm_in_if  #(.SAMPLE_BITS(SAMPLE_W)) in_ch ();
    pnsm_out_if #(.SAMPLE_BITS(SAMPLE_W)) out_ch ();

    pink_noise_shaper_mixer #(
        .SAMPLE_BITS(SAMPLE_W),
        .TAP_BITS   (TAP_W)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data),
        .sample_in (in_ch),
        .sample_out(out_ch)
    );

    // Predictor state: register copies and the seven filter taps.
    color_t       shade;
    gain_t        noise_level;
    longint       taps [7];

    sample_pair_t pending [$];
    sample_t      mixed_due [$];

    int           in_gap;
    int           out_gap;
    bit           calm;
    int           bad_beats;
    int           beats_out;
    int           pink_beats;
    int           white_beats;
    int           settings_seen;

    // Pole weight of each one-pole filter, signed Q.16.
    function automatic longint pole_weight(input int k);
        case (k)
            0:       return 65461;
            1:       return 65098;
            2:       return 63504;
            3:       return 56787;
            4:       return 36045;
            default: return -49912;
        endcase
    endfunction

    // Input weight of each one-pole filter, signed Q.16.
    function automatic longint feed_weight(input int k);
        case (k)
            0:       return 3638;
            1:       return 4920;
            2:       return 10083;
            3:       return 20348;
            4:       return 34928;
            default: return -1107;
        endcase
    endfunction

    // Product with a Q.16 weight, rounded half up.
    function automatic longint qmul(input longint x, input longint w);
        return (x * w + 64'sd32768) >>> 16;
    endfunction

    function automatic longint clamp(input longint x, input int bits);
        longint hi;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        if (x > hi)
            return hi;
        if (x < -hi - 1)
            return -hi - 1;
        return x;
    endfunction

    // Works out the mixed sample of one accepted beat and advances the taps in pink mode.
    function automatic sample_t mix_predict(input sample_t clean, input sample_t white);
        longint w;
        longint c;
        longint acc;
        longint noise;
        longint g;
        longint lim;
        int     k;
        w   = white;
        c   = clean;
        lim = (64'sd1 <<< (SAMPLE_W + 7)) - 1;
        if (shade == COLOR_PINK)
        begin
            acc = 0;
            for (k = 0; k < 6; k++)
            begin
                taps[k] = clamp(qmul(taps[k], pole_weight(k)) + qmul(w, feed_weight(k)), TAP_W);
                acc += taps[k];
            end
            acc += taps[6] + qmul(w, DIRECT_W);
            taps[6] = clamp(qmul(w, DELAY_W), TAP_W);
            noise = qmul(clamp(acc, TAP_W), NORM_W);
            pink_beats++;
        end
        else
        begin
            noise = w;
            white_beats++;
        end
        if (noise > lim)
            noise = lim;
        else if (noise < -lim)
            noise = -lim;
        g = noise_level;
        noise = (noise * g + (64'sd1 <<< (GAIN_SHIFT - 1))) >>> GAIN_SHIFT;
        return sample_t'(clamp(c + noise, SAMPLE_W));
    endfunction

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Input driver: presents queued beats, with occasional random gaps.
    always @(posedge clk or negedge rst_n)
    begin : drive_in
        sample_pair_t beat;
        if (!rst_n)
        begin
            in_ch.valid        <= 1'b0;
            in_ch.clean_sample <= '0;
            in_ch.white_sample <= '0;
            in_gap             <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                mixed_due.push_back(mix_predict(in_ch.clean_sample, in_ch.white_sample));
            if (!in_ch.valid || in_ch.ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap      <= in_gap - 1;
                    in_ch.valid <= 1'b0;
                end
                else if (!calm && $urandom_range(69) == 0)
                begin
                    in_gap      <= $urandom_range(7);
                    in_ch.valid <= 1'b0;
                end
                else if (pending.size() > 0)
                begin
                    beat               = pending.pop_front();
                    in_ch.valid        <= 1'b1;
                    in_ch.clean_sample <= beat.clean;
                    in_ch.white_sample <= beat.white;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // Output stall generator.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            out_gap      <= 0;
        end
        else if (out_gap > 0)
        begin
            out_gap      <= out_gap - 1;
            out_ch.ready <= 1'b0;
        end
        else if (!calm && $urandom_range(69) == 0)
        begin
            out_gap      <= $urandom_range(7);
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    // Output monitor: each accepted beat is checked against the oldest prediction.
    always @(posedge clk)
    begin : watch_out
        sample_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            beats_out++;
            if (mixed_due.size() == 0)
            begin
                if (bad_beats < 10)
                    $display("output beat %0d arrived with nothing predicted: got %0d",
                             beats_out, out_ch.mixed_sample);
                bad_beats++;
            end
            else
            begin
                want = mixed_due.pop_front();
                if (out_ch.mixed_sample !== want)
                begin
                    if (bad_beats < 10)
                        $display("mixed_sample mismatch on beat %0d: expected %0d, got %0d",
                                 beats_out, want, out_ch.mixed_sample);
                    bad_beats++;
                end
            end
        end
    end

    // Register write; the predictor copy follows at once since the block is idle.
    task automatic set_reg(input cfg_idx_t idx, input logic [GAIN_BITS-1:0] value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        if (idx == CFG_NOISE_COLOR)
            shade = color_t'(value[0]);
        else
            noise_level = value;
    endtask

    // Waits until every queued beat went in and every predicted beat came out.
    task automatic settle();
        do
            @(negedge clk);
        while (pending.size() != 0 || in_ch.valid || mixed_due.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic queue_beat(input sample_t clean, input sample_t white);
        pending.push_back('{clean: clean, white: white});
    endtask

    // Random sample with extra weight on the extremes.
    function automatic sample_t pick_sample();
        case ($urandom_range(15))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return '0;
            3:       return '1;
            default: return sample_t'($urandom());
        endcase
    endfunction

    // One setting of both registers followed by random beats; held runs of an extreme
    // white value drive the filter taps far from zero.
    task automatic run_phase(input logic [GAIN_BITS-1:0] color_word, input gain_t g,
                             input int count, input bit quiet);
        int      i;
        int      hold;
        sample_t held;
        set_reg(CFG_NOISE_COLOR, color_word);
        set_reg(CFG_NOISE_GAIN, g);
        settings_seen++;
        calm = quiet;
        hold = 0;
        held = '0;
        for (i = 0; i < count; i++)
        begin
            if (hold == 0 && $urandom_range(59) == 0)
            begin
                hold = $urandom_range(20, 60);
                held = $urandom_range(1) ? S_MAX : S_MIN;
            end
            if (hold > 0)
            begin
                hold--;
                queue_beat(pick_sample(), held);
            end
            else
                queue_beat(pick_sample(), pick_sample());
        end
        settle();
        calm = 1'b0;
    endtask

    // Stimulus and end of run.
    initial
    begin
        int i;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = CFG_NOISE_COLOR;
        cfg_data           = '0;
        calm               = 1'b0;
        bad_beats          = 0;
        beats_out          = 0;
        pink_beats         = 0;
        white_beats        = 0;
        settings_seen      = 1;
        shade              = COLOR_PINK;
        noise_level        = GAIN_RESET;
        for (i = 0; i < 7; i++)
            taps[i] = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: pink noise at the small default gain.
        queue_beat('0, '0);
        queue_beat(S_MAX, S_MAX);
        queue_beat(S_MIN, S_MIN);
        queue_beat(S_MAX, S_MIN);
        queue_beat(S_MIN, S_MAX);
        queue_beat('0, '1);
        queue_beat('0, 24'sd1);
        queue_beat(24'h555555, 24'hAAAAAA);
        settle();

        // White noise at full gain; upper bits of the color word are dropped.
        set_reg(CFG_NOISE_COLOR, 24'hFFFFFE);
        set_reg(CFG_NOISE_GAIN, GAIN_FULL);
        settings_seen++;
        queue_beat(S_MAX, S_MAX);
        queue_beat(S_MIN, S_MIN);
        queue_beat('0, S_MAX);
        queue_beat('0, S_MIN);
        queue_beat('0, '1);
        queue_beat('1, 24'sd1);
        settle();

        // Zero gain leaves the clean sample untouched.
        set_reg(CFG_NOISE_GAIN, '0);
        settings_seen++;
        queue_beat(24'sd123, S_MAX);
        queue_beat(S_MIN, S_MIN);
        settle();

        // Pink noise at full gain with a held full-scale white input.
        set_reg(CFG_NOISE_COLOR, 24'hFFFFFF);
        set_reg(CFG_NOISE_GAIN, GAIN_FULL);
        settings_seen++;
        for (i = 0; i < 6; i++)
            queue_beat('0, S_MAX);
        queue_beat('0, S_MIN);
        queue_beat(S_MAX, S_MAX);
        settle();

        // Random part over a spread of settings; the third runs without any idling.
        run_phase({23'd0, COLOR_PINK}, GAIN_RESET, 300, 1'b0);
        run_phase(24'hFFFFFE, gain_t'($urandom_range(0, 24'hFFFFFF)), 200, 1'b0);
        run_phase({23'd0, COLOR_PINK}, GAIN_FULL, 250, 1'b1);
        run_phase({23'd0, COLOR_WHITE}, '0, 150, 1'b0);
        run_phase({23'd0, COLOR_PINK}, '0, 150, 1'b0);
        run_phase({23'd0, COLOR_PINK}, gain_t'($urandom_range(0, 24'hFFFFFF)), 300, 1'b0);
        run_phase({23'd0, COLOR_WHITE}, GAIN_FULL, 200, 1'b0);
        run_phase({23'd0, COLOR_PINK}, gain_t'($urandom_range(0, 24'hFFFFFF)), 300, 1'b0);

        repeat (40) @(posedge clk);
        if (mixed_due.size() != 0)
            $display("%0d predicted beats never came out", mixed_due.size());
        $display("Ran %0d input beats (%0d pink, %0d white) under %0d register settings.",
                 pink_beats + white_beats, pink_beats, white_beats, settings_seen);
        $display("Checked %0d output beats, %0d of them wrong or unexpected.",
                 beats_out, bad_beats);
        if (bad_beats == 0 && mixed_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
